FILE: hw/rtl/cdate_pkg.sv
`timescale 1ns / 1ps
// cdate_pkg: types, constants, microprogram and calendar tables for the date adder.
// No dependencies. Used by calendar_date_add_and_serial.
package cdate_pkg;

  localparam int ACC_W = 21;
  localparam int YR_W  = 13;
  localparam int CNT_W = 5;
  localparam int PC_W  = 4;
  localparam int K_W   = 18;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_DATE = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [PC_W-1:0] PC_DONE = 4'd13;

  typedef enum logic [3:0] {
    UOP_DIV,
    UOP_CHECK,
    UOP_MUL365,
    UOP_ADDLEAP,
    UOP_ADDMON,
    UOP_SERIAL,
    UOP_SUB,
    UOP_RANGE,
    UOP_MONTH,
    UOP_FINISH,
    UOP_DONE
  } uop_t;

  typedef enum logic [1:0] {
    KS_400,
    KS_100,
    KS_4,
    KS_1
  } ksel_t;

  typedef struct packed {
    uop_t            op;
    ksel_t           ksel;
    logic [PC_W-1:0] tgt;
  } uword_t;

  // Control store. tgt is taken when the step's condition holds, else pc + 1.
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      4'd0:    w = '{UOP_DIV,     KS_400, 4'd0};
      4'd1:    w = '{UOP_CHECK,   KS_400, PC_DONE};
      4'd2:    w = '{UOP_MUL365,  KS_400, 4'd0};
      4'd3:    w = '{UOP_ADDLEAP, KS_400, 4'd0};
      4'd4:    w = '{UOP_ADDMON,  KS_400, 4'd0};
      4'd5:    w = '{UOP_SERIAL,  KS_400, 4'd0};
      4'd6:    w = '{UOP_SUB,     KS_400, 4'd6};
      4'd7:    w = '{UOP_SUB,     KS_100, 4'd7};
      4'd8:    w = '{UOP_SUB,     KS_4,   4'd8};
      4'd9:    w = '{UOP_SUB,     KS_1,   4'd9};
      4'd10:   w = '{UOP_RANGE,   KS_400, PC_DONE};
      4'd11:   w = '{UOP_MONTH,   KS_400, 4'd11};
      4'd12:   w = '{UOP_FINISH,  KS_400, 4'd0};
      default: w = '{UOP_DONE,    KS_400, PC_DONE};
    endcase
    return w;
  endfunction

  function automatic logic [K_W-1:0] k_days(input ksel_t k);
    logic [K_W-1:0] v;
    case (k)
      KS_400:  v = 18'd146097;
      KS_100:  v = 18'd36524;
      KS_4:    v = 18'd1461;
      default: v = 18'd365;
    endcase
    return v;
  endfunction

  function automatic logic [CNT_W-1:0] k_cap(input ksel_t k);
    logic [CNT_W-1:0] v;
    case (k)
      KS_100:  v = 5'd3;
      KS_1:    v = 5'd3;
      default: v = 5'd31;
    endcase
    return v;
  endfunction

  function automatic logic [8:0] k_years(input ksel_t k);
    logic [8:0] v;
    case (k)
      KS_400:  v = 9'd400;
      KS_100:  v = 9'd100;
      KS_4:    v = 9'd4;
      default: v = 9'd1;
    endcase
    return v;
  endfunction

  // floor(y / 100) for a 12-bit year: (y / 4) * 41 / 1024 is exact below 4096.
  function automatic logic [5:0] div100(input logic [11:0] y);
    logic [15:0] p;
    p = 16'(y[11:2]) * 16'd41;
    return p[15:10];
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] v;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: v = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     v = 5'd30;
      4'd2:    v = leap ? 5'd29 : 5'd28;
      default: v = 5'd0;
    endcase
    return v;
  endfunction

  function automatic logic [8:0] days_before(input logic [3:0] m, input logic leap);
    logic [8:0] v;
    case (m)
      4'd1:    v = 9'd0;
      4'd2:    v = 9'd31;
      4'd3:    v = 9'd59;
      4'd4:    v = 9'd90;
      4'd5:    v = 9'd120;
      4'd6:    v = 9'd151;
      4'd7:    v = 9'd181;
      4'd8:    v = 9'd212;
      4'd9:    v = 9'd243;
      4'd10:   v = 9'd273;
      4'd11:   v = 9'd304;
      default: v = 9'd334;
    endcase
    if (leap && m > 4'd2) begin
      v = v + 9'd1;
    end
    return v;
  endfunction

endpackage

FILE: hw/rtl/calendar_date_add_and_serial.sv
`timescale 1ns / 1ps
// calendar_date_add_and_serial: Gregorian date plus day count, and serial day number.
// Depends on cdate_pkg (microprogram, calendar tables, types).

// One request at a time runs through a 14-step microprogram on a single
// accumulator datapath. The start date is turned into an absolute day count
// with a closed form, the offset is added, and the sum is split back into a
// year by repeated subtraction of 400-, 100-, 4- and 1-year blocks, then into
// a month by subtracting month lengths. How long a request runs is set by the
// number of block subtractions (up to 5 + 3 + 24 + 3 at the default span) and
// month steps (up to 11). An invalid start date skips straight to the last
// step. The last step waits while an earlier result is still held in the
// output register. A new request is taken in the cycle after the result is
// loaded into the output register.
module calendar_date_add_and_serial #(
  parameter int REF_YEAR  = 1900,
  parameter int YEAR_SPAN = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [4:0]  in_day,
  input  logic [3:0]  in_month,
  input  logic [11:0] in_year,
  input  logic [15:0] offset_days,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  res_day,
  output logic [3:0]  res_month,
  output logic [11:0] res_year,
  output logic [16:0] serial_day,
  output logic [1:0]  status
);
  import cdate_pkg::*;

  localparam int LAST_YEAR = REF_YEAR + YEAR_SPAN - 1;
  localparam int REF_Z     = REF_YEAR - 1;
  localparam int REF_BASE  = 365 * REF_Z + REF_Z / 4 - REF_Z / 100 + REF_Z / 400;
  localparam logic [ACC_W-1:0] REF_BASE_A = ACC_W'(REF_BASE);

  logic                busy;
  logic [PC_W-1:0]     pc;

  logic [4:0]          start_day;
  logic [3:0]          start_month;
  logic [11:0]         start_year;
  logic [15:0]         offset;
  logic [5:0]          yq;
  logic [5:0]          zq;
  logic                leap;
  logic [ACC_W-1:0]    acc;
  logic [YR_W-1:0]     yr;
  logic [3:0]          mo;
  logic [CNT_W-1:0]    cnt;
  logic [1:0]          c100;
  logic [CNT_W-1:0]    c4;
  logic [1:0]          c1;
  logic [16:0]         serial;
  logic [1:0]          sts;
  logic [4:0]          fday;
  logic [3:0]          fmonth;
  logic [11:0]         fyear;

  uword_t              uw;
  logic                cond;
  logic [PC_W-1:0]     pc_next;
  logic [11:0]         zy;
  logic                leap_in;
  logic                date_bad;
  logic                leap_y;
  logic [4:0]          mlen_cur;
  logic [ACC_W-1:0]    kd;
  logic [ACC_W-1:0]    ser_diff;
  logic [9:0]          yq25;
  logic                out_load;

  assign in_ready = !busy;

  always_comb begin
    uw       = ucode(pc);
    zy       = start_year - 12'd1;
    yq25     = 10'(yq) * 10'd25;
    leap_in  = (start_year[1:0] == 2'd0) && ((start_year[11:2] != yq25) || (yq[1:0] == 2'd0));
    date_bad = (start_month == 4'd0) || (start_month > 4'd12) ||
               (32'(start_year) < 32'(REF_YEAR)) || (32'(start_year) > 32'(LAST_YEAR)) ||
               (start_day == 5'd0) || (start_day > month_len(start_month, leap_in));
    // year = 400a + 100b + 4c + d + 1, so the leap test reads off the block counts
    leap_y   = (c1 == 2'd3) && ((c4 != 5'd24) || (c100 == 2'd3));
    mlen_cur = month_len(mo, leap_y);
    kd       = ACC_W'(k_days(uw.ksel));
    ser_diff = acc - REF_BASE_A;
    case (uw.op)
      UOP_CHECK: cond = date_bad;
      UOP_SUB:   cond = (acc >= kd) && (cnt != k_cap(uw.ksel));
      UOP_RANGE: cond = 32'(yr) > 32'(LAST_YEAR);
      UOP_MONTH: cond = (mo < 4'd12) && (acc >= ACC_W'(mlen_cur));
      UOP_DONE:  cond = out_valid && !out_ready;
      default:   cond = 1'b0;
    endcase
    pc_next  = cond ? uw.tgt : pc + 4'd1;
    out_load = busy && (uw.op == UOP_DONE) && !cond;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pc        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (!busy) begin
        if (in_valid) begin
          busy        <= 1'b1;
          pc          <= '0;
          start_day   <= in_day;
          start_month <= in_month;
          start_year  <= in_year;
          offset      <= offset_days;
          sts         <= ST_OK;
          serial      <= '0;
          fday        <= '0;
          fmonth      <= '0;
          fyear       <= '0;
        end
      end else begin
        pc <= pc_next;
        case (uw.op)
          UOP_DIV: begin
            yq <= div100(start_year);
            zq <= div100(zy);
          end
          UOP_CHECK: begin
            leap <= leap_in;
            if (cond) begin
              sts <= ST_BAD_DATE;
            end
          end
          UOP_MUL365: begin
            acc <= ACC_W'(zy) * ACC_W'(9'd365);
          end
          UOP_ADDLEAP: begin
            acc <= acc + ACC_W'(zy[11:2]) - ACC_W'(zq) + ACC_W'(zq[5:2]);
          end
          UOP_ADDMON: begin
            acc <= acc + ACC_W'(days_before(start_month, leap)) + ACC_W'(start_day) - ACC_W'(1);
          end
          UOP_SERIAL: begin
            serial <= ser_diff[16:0];
            acc    <= acc + ACC_W'(offset);
            yr     <= YR_W'(1);
            cnt    <= '0;
          end
          UOP_SUB: begin
            if (cond) begin
              acc <= acc - kd;
              yr  <= yr + YR_W'(k_years(uw.ksel));
              cnt <= cnt + 5'd1;
            end else begin
              cnt <= '0;
              case (uw.ksel)
                KS_100:  c100 <= cnt[1:0];
                KS_4:    c4   <= cnt;
                KS_1:    c1   <= cnt[1:0];
                default: ;
              endcase
            end
          end
          UOP_RANGE: begin
            mo <= 4'd1;
            if (cond) begin
              sts <= ST_OVERFLOW;
            end
          end
          UOP_MONTH: begin
            if (cond) begin
              acc <= acc - ACC_W'(mlen_cur);
              mo  <= mo + 4'd1;
            end
          end
          UOP_FINISH: begin
            fday   <= acc[4:0] + 5'd1;
            fmonth <= mo;
            fyear  <= yr[11:0];
          end
          UOP_DONE: begin
            if (!cond) begin
              res_day    <= fday;
              res_month  <= fmonth;
              res_year   <= fyear;
              serial_day <= serial;
              status     <= sts;
              busy       <= 1'b0;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule
